[src/mbct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbct_pkg
// Event codes, register indexes and field widths of the pointer event tracker.
// ----------------------------------------------------------------------------
package mbct_pkg;

	// event kinds
	localparam logic [2:0] MODE_MOVE    = 3'd0;
	localparam logic [2:0] MODE_PRESS   = 3'd1;
	localparam logic [2:0] MODE_RELEASE = 3'd2;
	localparam logic [2:0] MODE_SCROLL  = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DC_WINDOW   = 2'd2;

	// reset values of the registers
	localparam logic [7:0]  HALF_WIDTH_RST  = 8'd2;
	localparam logic [7:0]  HALF_HEIGHT_RST = 8'd2;
	localparam logic [15:0] DC_WINDOW_RST   = 16'd500;

	// field widths
	localparam int unsigned TIME_W  = 61;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned COUNT_W = 8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	localparam logic signed [COORD_W:0] WHEEL_MAX = 17'sd32767;
	localparam logic signed [COORD_W:0] WHEEL_MIN = -17'sd32768;

	// per-button status flags
	typedef struct packed {
		logic held;
		logic released;
		logic pressed;
	} btn_flags_t;

endpackage
`default_nettype wire

[src/mouse_button_click_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_button_click_tracker
// Pointer event tracker: position, wheel, per-button flags and multi-click
// counting, one status report per event.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  event     in_valid / in_stall  mode, button, coord_x, coord_y, tick_time
//  status    out_valid/out_stall  flags, held_duration, click_count, pointer,
//                                 wheel
//  config    cfg_write            cfg_index, cfg_data (no read-back)
//
//  An event is registered in the input register on acceptance and applied
//  as it advances, when its status is loaded into the output register. One
//  event per cycle is sustained while out_stall is low; the output register
//  and the input register form a two-entry pipe, so in_stall rises only when
//  both are full and out_stall is high. Reset clears all tracker state at once.
// ----------------------------------------------------------------------------
module mouse_button_click_tracker #(
	parameter int unsigned NUM_BUTTONS = 5
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_write,
	input  wire logic [mbct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mbct_pkg::CFG_DATA_W-1:0]      cfg_data,
	// event request
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [2:0]                           mode,
	input  wire logic [2:0]                           button,
	input  wire logic signed [mbct_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [mbct_pkg::COORD_W-1:0]  coord_y,
	input  wire logic [mbct_pkg::TIME_W-1:0]          tick_time,
	// status request
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      press_seen,
	output logic                                      release_seen,
	output logic                                      is_held,
	output logic [mbct_pkg::TIME_W-1:0]               held_duration,
	output logic [mbct_pkg::COUNT_W-1:0]              click_count,
	output logic signed [mbct_pkg::COORD_W-1:0]       pointer_x,
	output logic signed [mbct_pkg::COORD_W-1:0]       pointer_y,
	output logic signed [mbct_pkg::COORD_W-1:0]       wheel_x,
	output logic signed [mbct_pkg::COORD_W-1:0]       wheel_y
);

	localparam int unsigned TW = mbct_pkg::TIME_W;
	localparam int unsigned CW = mbct_pkg::COORD_W;
	localparam logic [2:0] NO_BUTTON = 3'(NUM_BUTTONS);

	// configuration registers
	logic [7:0]  half_w_q;
	logic [7:0]  half_h_q;
	logic [15:0] dc_window_q;

	// input stage
	logic                 valid_s1;
	logic [2:0]           mode_s1;
	logic [2:0]           button_s1;
	logic signed [CW-1:0] coord_x_s1;
	logic signed [CW-1:0] coord_y_s1;
	logic [TW-1:0]        tick_time_s1;

	// tracker state
	mbct_pkg::btn_flags_t flags_q [NUM_BUTTONS];
	logic [TW-1:0]        stamp_q [NUM_BUTTONS];
	logic [TW-1:0]        now_q;
	logic signed [CW-1:0] cursor_x_q;
	logic signed [CW-1:0] cursor_y_q;
	logic signed [CW-1:0] scroll_x_q;
	logic signed [CW-1:0] scroll_y_q;
	logic [2:0]           prev_btn_q;
	logic signed [CW-1:0] prev_x_q;
	logic signed [CW-1:0] prev_y_q;
	logic [TW-1:0]        prev_time_q;
	logic [7:0]           clicks_q;

	// output register
	logic out_valid_q;

	// next-state values
	mbct_pkg::btn_flags_t flags_n [NUM_BUTTONS];
	logic [TW-1:0]        now_n;
	logic signed [CW-1:0] cursor_x_n;
	logic signed [CW-1:0] cursor_y_n;
	logic signed [CW-1:0] scroll_x_n;
	logic signed [CW-1:0] scroll_y_n;
	logic [7:0]           clicks_n;
	logic                 do_press;
	logic                 do_release;
	logic                 btn_ok;
	mbct_pkg::btn_flags_t sel_flags;
	logic [TW-1:0]        sel_stamp;
	logic [TW-1:0]        dur;
	logic                 adv_s1;
	logic                 out_free;

	// box and window checks
	logic signed [CW+1:0] cx_e;
	logic signed [CW+1:0] cy_e;
	logic signed [CW+1:0] px_e;
	logic signed [CW+1:0] py_e;
	logic signed [CW+1:0] w_e;
	logic signed [CW+1:0] h_e;
	logic                 in_box;
	logic [TW:0]          since_click;
	logic                 in_time;
	logic signed [CW:0]   sum_x;
	logic signed [CW:0]   sum_y;

	// pipeline flow
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign out_valid = out_valid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q    <= mbct_pkg::HALF_WIDTH_RST;
			half_h_q    <= mbct_pkg::HALF_HEIGHT_RST;
			dc_window_q <= mbct_pkg::DC_WINDOW_RST;
		end else if (cfg_write) begin
			if (cfg_index == mbct_pkg::REG_HALF_WIDTH) begin
				half_w_q <= cfg_data[7:0];
			end
			if (cfg_index == mbct_pkg::REG_HALF_HEIGHT) begin
				half_h_q <= cfg_data[7:0];
			end
			if (cfg_index == mbct_pkg::REG_DC_WINDOW) begin
				dc_window_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1      <= mode;
			button_s1    <= button;
			coord_x_s1   <= coord_x;
			coord_y_s1   <= coord_y;
			tick_time_s1 <= tick_time;
		end
	end

	// multi-click box and window test against the last click
	always_comb begin
		cx_e = (CW+2)'(cursor_x_q);
		cy_e = (CW+2)'(cursor_y_q);
		px_e = (CW+2)'(prev_x_q);
		py_e = (CW+2)'(prev_y_q);
		w_e  = $signed({{(CW-6){1'b0}}, half_w_q});
		h_e  = $signed({{(CW-6){1'b0}}, half_h_q});
		in_box = (cx_e >= px_e - w_e) && (cx_e < px_e + w_e) &&
			(cy_e >= py_e - h_e) && (cy_e < py_e + h_e);
		since_click = {1'b0, now_q} - {1'b0, prev_time_q};
		in_time = !since_click[TW] && (since_click[TW-1:16] == '0) &&
			(since_click[15:0] <= dc_window_q);
	end

	// event decode and state update
	always_comb begin
		btn_ok     = button_s1 < NO_BUTTON;
		do_press   = (mode_s1 == mbct_pkg::MODE_PRESS) && btn_ok;
		do_release = (mode_s1 == mbct_pkg::MODE_RELEASE) && btn_ok;
		now_n      = (mode_s1 == mbct_pkg::MODE_TICK) ? tick_time_s1 : now_q;
		cursor_x_n = cursor_x_q;
		cursor_y_n = cursor_y_q;
		if (mode_s1 == mbct_pkg::MODE_MOVE) begin
			cursor_x_n = coord_x_s1;
			cursor_y_n = coord_y_s1;
		end

		// saturating wheel sums
		sum_x = (CW+1)'(scroll_x_q) + (CW+1)'(coord_x_s1);
		sum_y = (CW+1)'(scroll_y_q) + (CW+1)'(coord_y_s1);
		scroll_x_n = scroll_x_q;
		scroll_y_n = scroll_y_q;
		if (mode_s1 == mbct_pkg::MODE_SCROLL) begin
			scroll_x_n = (sum_x > mbct_pkg::WHEEL_MAX) ? 16'sh7FFF :
				(sum_x < mbct_pkg::WHEEL_MIN) ? 16'sh8000 : sum_x[CW-1:0];
			scroll_y_n = (sum_y > mbct_pkg::WHEEL_MAX) ? 16'sh7FFF :
				(sum_y < mbct_pkg::WHEEL_MIN) ? 16'sh8000 : sum_y[CW-1:0];
		end else if (mode_s1 == mbct_pkg::MODE_TICK) begin
			scroll_x_n = '0;
			scroll_y_n = '0;
		end

		// click run count
		clicks_n = clicks_q;
		if (do_press) begin
			if (button_s1 != prev_btn_q || !in_box || !in_time) begin
				clicks_n = 8'd1;
			end else if (clicks_q != mbct_pkg::COUNT_MAX) begin
				clicks_n = clicks_q + 8'd1;
			end
		end

		// per-button flags and report select
		sel_flags = '0;
		sel_stamp = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			flags_n[i] = flags_q[i];
			if (mode_s1 == mbct_pkg::MODE_TICK) begin
				flags_n[i].pressed  = 1'b0;
				flags_n[i].released = 1'b0;
			end
			if (button_s1 == 3'(i)) begin
				if (do_press) begin
					flags_n[i].pressed = 1'b1;
					flags_n[i].held    = 1'b1;
				end
				if (do_release) begin
					flags_n[i].released = 1'b1;
					flags_n[i].held     = 1'b0;
				end
				sel_flags = flags_n[i];
				sel_stamp = do_press ? now_q : stamp_q[i];
			end
		end
		dur = sel_flags.held ? (now_n - sel_stamp) : '0;
	end

	// tracker state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				flags_q[i] <= '0;
				stamp_q[i] <= '0;
			end
			now_q       <= '0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			scroll_x_q  <= '0;
			scroll_y_q  <= '0;
			prev_btn_q  <= NO_BUTTON;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_time_q <= '0;
			clicks_q    <= '0;
		end else if (adv_s1) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				flags_q[i] <= flags_n[i];
				if (do_press && button_s1 == 3'(i)) begin
					stamp_q[i] <= now_q;
				end
			end
			now_q      <= now_n;
			cursor_x_q <= cursor_x_n;
			cursor_y_q <= cursor_y_n;
			scroll_x_q <= scroll_x_n;
			scroll_y_q <= scroll_y_n;
			clicks_q   <= clicks_n;
			if (do_press) begin
				prev_btn_q  <= button_s1;
				prev_x_q    <= cursor_x_q;
				prev_y_q    <= cursor_y_q;
				prev_time_q <= now_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			press_seen    <= sel_flags.pressed;
			release_seen  <= sel_flags.released;
			is_held       <= sel_flags.held;
			held_duration <= dur;
			click_count   <= clicks_n;
			pointer_x     <= cursor_x_n;
			pointer_y     <= cursor_y_n;
			wheel_x       <= scroll_x_n;
			wheel_y       <= scroll_y_n;
		end
	end

	// a run count of zero means no press has been seen yet
	a_clicks_vs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(clicks_q == 8'd0) == (prev_btn_q == NO_BUTTON))
		else $error("click count and last click button disagree");

	// a tick reports a cleared wheel
	a_tick_clears_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && mode_s1 == mbct_pkg::MODE_TICK) |=> (wheel_x == '0 && wheel_y == '0))
		else $error("wheel not cleared after tick");

	// an event waiting behind a stalled report is kept
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1)
		else $error("pending event lost under stall");

	// a reported press always shows its button held
	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && do_press) |=> (out_valid && is_held && press_seen))
		else $error("press not reported as held");

endmodule
`default_nettype wire
